// ===== sv/mexp_pkg.sv =====
package mexp_pkg;

    localparam int FIELD_W = 64;
    localparam int WIDTH   = 64;
    localparam int CNT_W   = $clog2(WIDTH);

    typedef struct packed {
        logic [FIELD_W-1:0] base;
        logic [FIELD_W-1:0] exponent;
        logic [FIELD_W-1:0] modulus;
    } in_t;

    typedef struct packed {
        logic [FIELD_W-1:0] power_mod;
        logic               bad_modulus;
    } out_t;

    typedef struct packed {
        logic [WIDTH-1:0] a;
        logic [WIDTH-1:0] b;
        logic [WIDTH-1:0] m;
    } mm_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mm_stat_t;

endpackage

// ===== sv/modular_exponentiation.sv =====
// channel   direction  handshake             payload
// operands  in         start && !busy        mexp_pkg::in_t  (base, exponent, modulus)
// result    out        done, one cycle       mexp_pkg::out_t (power_mod, bad_modulus)
//
// Exponent 0 or 1, or zero modulus: result strobes on the cycle after the beat.
// Otherwise base is reduced mod modulus and the exponent is scanned from its top bit;
// past the top set bit each bit squares r, and a set bit then multiplies r by base.
// Each product comes from the shared shift-and-add modular multiplier, one bit a cycle.
// On the multiplier path busy is high from the accepted beat until the result strobe; rst_n clears control.
// The receiver cannot stall: done lasts one cycle and the result is taken then.
module modular_exponentiation (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  mexp_pkg::in_t  operands,
    output logic           busy,
    output logic           done,
    output mexp_pkg::out_t result
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RED  = 5'b00010,
        S_SCAN = 5'b00100,
        S_SQ   = 5'b01000,
        S_MUL  = 5'b10000
    } state_t;

    state_t                       state_reg, state_next;
    logic [mexp_pkg::WIDTH-1:0]   e_reg, e_next;
    logic [mexp_pkg::WIDTH-1:0]   m_reg, m_next;
    logic [mexp_pkg::WIDTH-1:0]   base_reg, base_next;
    logic [mexp_pkg::WIDTH-1:0]   r_reg, r_next;
    logic                         started_reg, started_next;
    logic [mexp_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                         done_reg, done_next;
    mexp_pkg::out_t               res_reg, res_next;

    logic                         mm_start;
    mexp_pkg::mm_req_t            mm_req;
    mexp_pkg::mm_stat_t           mm_stat;
    logic [mexp_pkg::WIDTH-1:0]   mm_product;
    logic                         adv;

    logic [mexp_pkg::WIDTH-1:0]   in_b;
    logic [mexp_pkg::WIDTH-1:0]   in_e;
    logic [mexp_pkg::WIDTH-1:0]   in_m;

    assign in_b = operands.base[mexp_pkg::WIDTH-1:0];
    assign in_e = operands.exponent[mexp_pkg::WIDTH-1:0];
    assign in_m = operands.modulus[mexp_pkg::WIDTH-1:0];

    mexp_mulmod u_mulmod (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_start (mm_start),
        .req       (mm_req),
        .stat      (mm_stat),
        .product   (mm_product)
    );

    always_comb
    begin
        state_next   = state_reg;
        e_next       = e_reg;
        m_next       = m_reg;
        base_next    = base_reg;
        r_next       = r_reg;
        started_next = started_reg;
        cnt_next     = cnt_reg;
        done_next    = 1'b0;
        res_next     = res_reg;
        mm_start     = 1'b0;
        mm_req       = '{a: r_reg, b: r_reg, m: m_reg};
        adv          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    e_next       = in_e;
                    m_next       = in_m;
                    base_next    = in_b;
                    started_next = 1'b0;
                    cnt_next     = mexp_pkg::CNT_W'(mexp_pkg::WIDTH - 1);
                    if (in_e == '0)
                    begin
                        done_next = 1'b1;
                        res_next  = '{power_mod: mexp_pkg::FIELD_W'(1), bad_modulus: 1'b0};
                    end
                    else if (in_e == mexp_pkg::WIDTH'(1))
                    begin
                        done_next = 1'b1;
                        res_next  = '{power_mod: mexp_pkg::FIELD_W'(in_b), bad_modulus: 1'b0};
                    end
                    else if (in_m == '0)
                    begin
                        done_next = 1'b1;
                        res_next  = '{power_mod: '0, bad_modulus: 1'b1};
                    end
                    else
                    begin
                        // base mod m as (1 mod m) * base
                        mm_start   = 1'b1;
                        mm_req     = '{a: (in_m == mexp_pkg::WIDTH'(1)) ? '0
                                                                    : mexp_pkg::WIDTH'(1),
                                       b: in_b, m: in_m};
                        state_next = S_RED;
                    end
                end
            end
            S_RED:
            begin
                if (mm_stat.done)
                begin
                    base_next  = mm_product;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (started_reg)
                begin
                    mm_start   = 1'b1;
                    state_next = S_SQ;
                end
                else
                begin
                    // leading zeros leave r untouched; first set bit loads the base
                    if (e_reg[mexp_pkg::WIDTH-1])
                    begin
                        r_next       = base_reg;
                        started_next = 1'b1;
                    end
                    adv = 1'b1;
                end
            end
            S_SQ:
            begin
                if (mm_stat.done)
                begin
                    r_next = mm_product;
                    if (e_reg[mexp_pkg::WIDTH-1])
                    begin
                        mm_start   = 1'b1;
                        mm_req     = '{a: mm_product, b: base_reg, m: m_reg};
                        state_next = S_MUL;
                    end
                    else
                    begin
                        adv = 1'b1;
                    end
                end
            end
            S_MUL:
            begin
                if (mm_stat.done)
                begin
                    r_next = mm_product;
                    adv    = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (adv)
        begin
            if (cnt_reg == '0)
            begin
                done_next  = 1'b1;
                res_next   = '{power_mod: mexp_pkg::FIELD_W'(r_next), bad_modulus: 1'b0};
                state_next = S_IDLE;
            end
            else
            begin
                cnt_next   = cnt_reg - 1'b1;
                e_next     = e_reg << 1;
                state_next = S_SCAN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            started_reg <= 1'b0;
            cnt_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            started_reg <= started_next;
            cnt_reg     <= cnt_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg    <= e_next;
        m_reg    <= m_next;
        base_reg <= base_next;
        r_reg    <= r_next;
        res_reg  <= res_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted beat gave neither busy nor result");

    a_mm_free: assert property (@(posedge clk) disable iff (!rst_n)
        mm_start |-> !mm_stat.busy)
        else $error("multiplier started while busy");

    a_mm_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mm_stat.done |-> (state_reg == S_RED || state_reg == S_SQ || state_reg == S_MUL))
        else $error("multiplier result with nobody waiting");

    a_r_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && started_reg) |-> (r_reg < m_reg))
        else $error("running power not reduced");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.bad_modulus) |-> (result.power_mod == '0))
        else $error("bad modulus with nonzero result");

endmodule

// ===== sv/mexp_mulmod.sv =====
module mexp_mulmod (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_start,
    input  mexp_pkg::mm_req_t  req,
    output mexp_pkg::mm_stat_t stat,
    output logic [mexp_pkg::WIDTH-1:0] product
);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [mexp_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [mexp_pkg::WIDTH-1:0]   acc_reg, acc_next;
    logic [mexp_pkg::WIDTH-1:0]   a_reg, a_next;
    logic [mexp_pkg::WIDTH-1:0]   b_reg, b_next;
    logic [mexp_pkg::WIDTH-1:0]   m_reg, m_next;

    // one multiplier bit per cycle: acc = (2*acc + bit*a) mod m, sum below 3m
    logic [mexp_pkg::WIDTH+1:0]   sum;
    logic [mexp_pkg::WIDTH+1:0]   m1;
    logic [mexp_pkg::WIDTH+1:0]   m2;
    logic [mexp_pkg::WIDTH-1:0]   step;

    always_comb
    begin
        m1  = {2'b00, m_reg};
        m2  = {1'b0, m_reg, 1'b0};
        sum = {1'b0, acc_reg, 1'b0}
            + (b_reg[mexp_pkg::WIDTH-1] ? {2'b00, a_reg} : '0);
        if (sum >= m2)
        begin
            step = mexp_pkg::WIDTH'(sum - m2);
        end
        else if (sum >= m1)
        begin
            step = mexp_pkg::WIDTH'(sum - m1);
        end
        else
        begin
            step = mexp_pkg::WIDTH'(sum);
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        if (busy_reg)
        begin
            acc_next = step;
            b_next   = b_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req_start)
        begin
            busy_next = 1'b1;
            cnt_next  = mexp_pkg::CNT_W'(mexp_pkg::WIDTH - 1);
            acc_next  = '0;
            a_next    = req.a;
            b_next    = req.b;
            m_next    = req.m;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = acc_reg;

endmodule
